/* hdl/dtmf_tone_burst_generator_defines.svh */
// Assertion macros for the DTMF tone burst generator.
`ifndef DTMF_TONE_BURST_GENERATOR_DEFINES_SVH
`define DTMF_TONE_BURST_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define DTMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define DTMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dtmf_pkg.sv */
// Shared constants and types of the DTMF tone burst generator.
package dtmf_pkg;

    localparam int unsigned SAMPLE_RATE      = 44100;
    localparam int unsigned PHASE_BITS       = 32;
    localparam int unsigned SINE_TABLE_DEPTH = 256;
    localparam int unsigned TBL_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned FRAC_BITS        = 16;
    localparam int unsigned FRAC_LSB         = PHASE_BITS - 2 - TBL_BITS - FRAC_BITS;
    localparam int unsigned ROM_BITS         = 15;
    localparam int unsigned MS_BITS          = 14;
    localparam int unsigned CNT_BITS         = 20;
    localparam int unsigned KEY_BITS         = 8;
    localparam int unsigned SAMPLE_BITS      = 16;
    localparam int unsigned CFG_INDEX_BITS   = 1;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [CNT_BITS-1:0]   count_t;
    typedef logic [MS_BITS-1:0]    ms_t;
    typedef logic [ROM_BITS-1:0]   rom_word_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TONE_MS = 1'b0,
        REG_GAP_MS  = 1'b1
    } cfg_reg_t;

    // Table lookup side information for one sine
    typedef struct packed {
        logic [1:0]           quad;
        logic                 lo0;
        logic [FRAC_BITS-1:0] frac;
    } tap_t;

    // Word in flight between the sequencer and the mixer
    typedef struct packed {
        logic valid;
        logic in_tone;
        logic burst_last;
        logic bad_key;
        tap_t row;
        tap_t col;
    } lane_t;

endpackage

/* hdl/dtmf_if.sv */
// Stream interfaces of the DTMF tone burst generator.
interface dtmf_key_if;
    import dtmf_pkg::*;

    logic                valid;
    logic                ready;
    logic                start_burst;
    logic [KEY_BITS-1:0] key_code;

    modport source (output valid, start_burst, key_code, input ready);
    modport sink   (input valid, start_burst, key_code, output ready);
endinterface

interface dtmf_sample_if;
    import dtmf_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          in_tone;
    logic                          burst_last;
    logic                          bad_key;

    modport source (output valid, sample, in_tone, burst_last, bad_key, input ready);
    modport sink   (input valid, sample, in_tone, burst_last, bad_key, output ready);
endinterface

/* hdl/dtmf_sine_rom.sv */
// Quarter-wave sine table split into even and odd banks with registered reads.
module dtmf_sine_rom (
    input  logic                          clk,
    input  logic                          en,
    input  logic [dtmf_pkg::TBL_BITS-1:0] lo,
    output dtmf_pkg::rom_word_t           even_q,
    output dtmf_pkg::rom_word_t           odd_q
);
    import dtmf_pkg::*;

    localparam int unsigned HALF        = SINE_TABLE_DEPTH / 2;
    localparam longint unsigned HalfPiQ30 = 64'd1686629713;
    localparam int unsigned SeriesShift = 42;

    // Series divisors (2n)(2n+1) as reciprocals rounded up; exact for every term that occurs
    localparam longint unsigned SeriesRecip [1:7] = '{
        ((64'd1 << SeriesShift) + 64'd5)   / 64'd6,
        ((64'd1 << SeriesShift) + 64'd19)  / 64'd20,
        ((64'd1 << SeriesShift) + 64'd41)  / 64'd42,
        ((64'd1 << SeriesShift) + 64'd71)  / 64'd72,
        ((64'd1 << SeriesShift) + 64'd109) / 64'd110,
        ((64'd1 << SeriesShift) + 64'd155) / 64'd156,
        ((64'd1 << SeriesShift) + 64'd209) / 64'd210
    };

    typedef rom_word_t even_bank_t [0:HALF];
    typedef rom_word_t odd_bank_t  [0:HALF-1];

    // round(32767 * sin(pi/2 * k / depth)) by a Q30 Taylor series
    function automatic rom_word_t quarter_sine(int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        logic [127:0]    wide;
        x    = (HalfPiQ30 * 64'(k)) / SINE_TABLE_DEPTH;
        term = x;
        sum  = longint'(x);
        for (int unsigned n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            wide = 128'(term) * 128'(SeriesRecip[n]);
            term = 64'(wide >> SeriesShift);
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) << 30))
            sum = longint'(1) << 30;
        return ROM_BITS'(($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic even_bank_t build_even();
        even_bank_t bank;
        for (int unsigned j = 0; j <= HALF; j++)
            bank[j] = quarter_sine(2 * j);
        return bank;
    endfunction

    function automatic odd_bank_t build_odd();
        odd_bank_t bank;
        for (int unsigned j = 0; j < HALF; j++)
            bank[j] = quarter_sine(2 * j + 1);
        return bank;
    endfunction

    localparam even_bank_t EvenBank = build_even();
    localparam odd_bank_t  OddBank  = build_odd();

    logic [TBL_BITS-1:0] even_addr;
    logic [TBL_BITS-2:0] odd_addr;
    rom_word_t           even_q_reg;
    rom_word_t           odd_q_reg;

    // Entries lo and lo+1 always fall in opposite banks
    assign odd_addr  = lo[TBL_BITS-1:1];
    assign even_addr = {1'b0, odd_addr} + TBL_BITS'(lo[0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            even_q_reg <= EvenBank[even_addr];
            odd_q_reg  <= OddBank[odd_addr];
        end
    end

    assign even_q = even_q_reg;
    assign odd_q  = odd_q_reg;

endmodule

/* hdl/dtmf_seq.sv */
// Burst sequencer: key decode, sample counters, phase accumulators, table addressing.
module dtmf_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic                                start_burst,
    input  logic [dtmf_pkg::KEY_BITS-1:0]       key_code,
    input  logic                                cfg_we,
    input  logic [dtmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  dtmf_pkg::ms_t                       cfg_wdata,
    output logic [dtmf_pkg::TBL_BITS-1:0]       row_lo,
    output logic [dtmf_pkg::TBL_BITS-1:0]       col_lo,
    output dtmf_pkg::lane_t                     lane
);
    import dtmf_pkg::*;

    localparam int unsigned SrInt     = SAMPLE_RATE / 1000;
    localparam int unsigned SrRem     = SAMPLE_RATE % 1000;
    localparam int unsigned RecipShift = 32;
    localparam longint unsigned FracMul =
        64'(SrRem) * (((64'd1 << RecipShift) + 64'd999) / 64'd1000);
    localparam int unsigned WIDE      = MS_BITS + $clog2(SrInt + 1) + 1;
    localparam int unsigned PROD_BITS = MS_BITS + 42;
    localparam count_t CntMax         = {CNT_BITS{1'b1}};
    localparam count_t FramesReset    = count_t'(100 * SAMPLE_RATE / 1000);

    localparam logic [KEY_BITS-1:0] KEY_0 = "0";
    localparam logic [KEY_BITS-1:0] KEY_1 = "1";
    localparam logic [KEY_BITS-1:0] KEY_2 = "2";
    localparam logic [KEY_BITS-1:0] KEY_3 = "3";
    localparam logic [KEY_BITS-1:0] KEY_4 = "4";
    localparam logic [KEY_BITS-1:0] KEY_5 = "5";
    localparam logic [KEY_BITS-1:0] KEY_6 = "6";
    localparam logic [KEY_BITS-1:0] KEY_7 = "7";
    localparam logic [KEY_BITS-1:0] KEY_8 = "8";
    localparam logic [KEY_BITS-1:0] KEY_9 = "9";
    localparam logic [KEY_BITS-1:0] KEY_A = "A";
    localparam logic [KEY_BITS-1:0] KEY_B = "B";
    localparam logic [KEY_BITS-1:0] KEY_C = "C";
    localparam logic [KEY_BITS-1:0] KEY_D = "D";
    localparam logic [KEY_BITS-1:0] KEY_STAR = "*";
    localparam logic [KEY_BITS-1:0] KEY_HASH = "#";

    function automatic phase_t step_for(longint unsigned freq);
        return phase_t'(((freq << PHASE_BITS) + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE);
    endfunction

    localparam phase_t ROW_STEPS [0:3] = '{step_for(697), step_for(770),
                                           step_for(852), step_for(941)};
    localparam phase_t COL_STEPS [0:3] = '{step_for(1209), step_for(1336),
                                           step_for(1477), step_for(1633)};

    typedef struct packed {
        logic       known;
        logic [1:0] row;
        logic [1:0] col;
    } key_cell_t;

    function automatic key_cell_t key_decode(logic [KEY_BITS-1:0] code);
        key_cell_t pos;
        pos = '0;
        pos.known = 1'b1;
        unique case (code)
            KEY_1:    begin pos.row = 2'd0; pos.col = 2'd0; end
            KEY_2:    begin pos.row = 2'd0; pos.col = 2'd1; end
            KEY_3:    begin pos.row = 2'd0; pos.col = 2'd2; end
            KEY_A:    begin pos.row = 2'd0; pos.col = 2'd3; end
            KEY_4:    begin pos.row = 2'd1; pos.col = 2'd0; end
            KEY_5:    begin pos.row = 2'd1; pos.col = 2'd1; end
            KEY_6:    begin pos.row = 2'd1; pos.col = 2'd2; end
            KEY_B:    begin pos.row = 2'd1; pos.col = 2'd3; end
            KEY_7:    begin pos.row = 2'd2; pos.col = 2'd0; end
            KEY_8:    begin pos.row = 2'd2; pos.col = 2'd1; end
            KEY_9:    begin pos.row = 2'd2; pos.col = 2'd2; end
            KEY_C:    begin pos.row = 2'd2; pos.col = 2'd3; end
            KEY_STAR: begin pos.row = 2'd3; pos.col = 2'd0; end
            KEY_0:    begin pos.row = 2'd3; pos.col = 2'd1; end
            KEY_HASH: begin pos.row = 2'd3; pos.col = 2'd2; end
            KEY_D:    begin pos.row = 2'd3; pos.col = 2'd3; end
            default:  pos.known = 1'b0;
        endcase
        return pos;
    endfunction

    count_t tone_frames_reg;
    count_t gap_frames_reg;
    phase_t row_phase_reg, row_phase_next;
    phase_t col_phase_reg, col_phase_next;
    phase_t row_step_reg, col_step_reg;
    count_t tone_left_reg, tone_left_next;
    count_t gap_left_reg, gap_left_next;
    lane_t  lane_reg, lane_next;

    key_cell_t            pad;
    logic                 accept;
    logic                 good_start;
    logic                 bad_start;
    logic                 playing;
    logic                 gapping;
    count_t               tone_cur;
    count_t               gap_cur;
    phase_t               row_phase_cur, col_phase_cur;
    phase_t               row_step_cur, col_step_cur;
    logic [TBL_BITS-1:0]  row_k, col_k;
    logic [WIDE-1:0]      int_part;
    logic [PROD_BITS-1:0] frac_prod;
    logic [WIDE-1:0]      frames_wide;
    count_t               cfg_frames;

    // ms * rate / 1000 as an integer part plus a reciprocal multiply
    always_comb
    begin
        int_part    = WIDE'(cfg_wdata) * WIDE'(SrInt);
        frac_prod   = PROD_BITS'(cfg_wdata) * PROD_BITS'(FracMul);
        frames_wide = int_part + WIDE'(frac_prod >> RecipShift);
        cfg_frames  = (frames_wide > WIDE'(CntMax)) ? CntMax : frames_wide[CNT_BITS-1:0];
    end

    always_comb
    begin
        accept     = in_valid && advance;
        pad        = key_decode(key_code);
        good_start = start_burst && pad.known;
        bad_start  = start_burst && !pad.known;

        // Apply the start first, then produce one sample
        if (good_start)
        begin
            tone_cur      = tone_frames_reg;
            gap_cur       = gap_frames_reg;
            row_phase_cur = '0;
            col_phase_cur = '0;
            row_step_cur  = ROW_STEPS[pad.row];
            col_step_cur  = COL_STEPS[pad.col];
        end
        else
        begin
            tone_cur      = bad_start ? '0 : tone_left_reg;
            gap_cur       = bad_start ? '0 : gap_left_reg;
            row_phase_cur = row_phase_reg;
            col_phase_cur = col_phase_reg;
            row_step_cur  = row_step_reg;
            col_step_cur  = col_step_reg;
        end

        playing = (tone_cur != '0);
        gapping = !playing && (gap_cur != '0);

        tone_left_next = playing ? tone_cur - count_t'(1) : tone_cur;
        gap_left_next  = gapping ? gap_cur - count_t'(1) : gap_cur;
        row_phase_next = playing ? row_phase_cur + row_step_cur : row_phase_cur;
        col_phase_next = playing ? col_phase_cur + col_step_cur : col_phase_cur;

        // Falling quadrants read the mirrored pair
        row_k  = row_phase_cur[PHASE_BITS-3 -: TBL_BITS];
        col_k  = col_phase_cur[PHASE_BITS-3 -: TBL_BITS];
        row_lo = row_phase_cur[PHASE_BITS-2] ? ~row_k : row_k;
        col_lo = col_phase_cur[PHASE_BITS-2] ? ~col_k : col_k;

        lane_next.valid      = in_valid;
        lane_next.in_tone    = playing;
        lane_next.burst_last = playing ? (tone_cur == count_t'(1) && gap_cur == '0)
                                       : (gapping && gap_cur == count_t'(1));
        lane_next.bad_key    = bad_start;
        lane_next.row.quad   = row_phase_cur[PHASE_BITS-1 -: 2];
        lane_next.row.lo0    = row_lo[0];
        lane_next.row.frac   = row_phase_cur[FRAC_LSB +: FRAC_BITS];
        lane_next.col.quad   = col_phase_cur[PHASE_BITS-1 -: 2];
        lane_next.col.lo0    = col_lo[0];
        lane_next.col.frac   = col_phase_cur[FRAC_LSB +: FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_frames_reg <= FramesReset;
            gap_frames_reg  <= FramesReset;
            row_phase_reg   <= '0;
            col_phase_reg   <= '0;
            row_step_reg    <= '0;
            col_step_reg    <= '0;
            tone_left_reg   <= '0;
            gap_left_reg    <= '0;
            lane_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TONE_MS: tone_frames_reg <= cfg_frames;
                    REG_GAP_MS:  gap_frames_reg  <= cfg_frames;
                endcase
            end
            if (accept)
            begin
                row_phase_reg <= row_phase_next;
                col_phase_reg <= col_phase_next;
                row_step_reg  <= row_step_cur;
                col_step_reg  <= col_step_cur;
                tone_left_reg <= tone_left_next;
                gap_left_reg  <= gap_left_next;
            end
            if (advance)
                lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

/* hdl/dtmf_mix.sv */
// Interpolation, sign, averaging and the output word register.
module dtmf_mix (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  dtmf_pkg::lane_t                      lane,
    input  dtmf_pkg::rom_word_t                  row_even,
    input  dtmf_pkg::rom_word_t                  row_odd,
    input  dtmf_pkg::rom_word_t                  col_even,
    input  dtmf_pkg::rom_word_t                  col_odd,
    output logic                                 out_valid,
    output logic signed [dtmf_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                 in_tone,
    output logic                                 burst_last,
    output logic                                 bad_key
);
    import dtmf_pkg::*;

    localparam int unsigned PROD_BITS = ROM_BITS + 1 + FRAC_BITS + 1;
    localparam int unsigned MAG_BITS  = ROM_BITS + 2;
    localparam logic signed [PROD_BITS:0] ROUND = 1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        rom_word_t                    base;
        logic signed [PROD_BITS-1:0]  prod;
    } interp_t;

    typedef struct packed {
        logic valid;
        logic in_tone;
        logic burst_last;
        logic bad_key;
        logic row_neg;
        logic col_neg;
    } ctl_t;

    // a + (b - a) * f, with a and b swapped in the falling quadrants
    function automatic interp_t interp(tap_t tap, rom_word_t ev, rom_word_t od);
        interp_t                    res;
        rom_word_t                  low;
        rom_word_t                  high;
        rom_word_t                  b;
        logic signed [ROM_BITS:0]   diff;
        logic signed [FRAC_BITS:0]  fs;
        low      = tap.lo0 ? od : ev;
        high     = tap.lo0 ? ev : od;
        res.base = tap.quad[0] ? high : low;
        b        = tap.quad[0] ? low : high;
        diff     = $signed({1'b0, b}) - $signed({1'b0, res.base});
        fs       = $signed({1'b0, tap.frac});
        res.prod = diff * fs;
        return res;
    endfunction

    function automatic logic signed [MAG_BITS-1:0] signed_mag(
        rom_word_t base, logic signed [PROD_BITS-1:0] prod, logic neg);
        logic signed [PROD_BITS:0]  rounded;
        logic signed [PROD_BITS:0]  shifted;
        logic signed [MAG_BITS-1:0] mag;
        rounded = prod + ROUND;
        shifted = rounded >>> FRAC_BITS;
        mag     = $signed({{(MAG_BITS - ROM_BITS){1'b0}}, base}) + shifted[MAG_BITS-1:0];
        return neg ? -mag : mag;
    endfunction

    interp_t row_terms, col_terms;
    ctl_t    ctl_reg, ctl_next;
    rom_word_t                   row_base_reg, col_base_reg;
    logic signed [PROD_BITS-1:0] row_prod_reg, col_prod_reg;

    logic signed [MAG_BITS-1:0]    row_mag, col_mag;
    logic signed [MAG_BITS:0]      sum, sum_adj, half;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          in_tone_reg, burst_last_reg, bad_key_reg;

    always_comb
    begin
        row_terms           = interp(lane.row, row_even, row_odd);
        col_terms           = interp(lane.col, col_even, col_odd);
        ctl_next.valid      = lane.valid;
        ctl_next.in_tone    = lane.in_tone;
        ctl_next.burst_last = lane.burst_last;
        ctl_next.bad_key    = lane.bad_key;
        ctl_next.row_neg    = lane.row.quad[1];
        ctl_next.col_neg    = lane.col.quad[1];
    end

    // Average of the two sines, truncated toward zero
    always_comb
    begin
        row_mag     = signed_mag(row_base_reg, row_prod_reg, ctl_reg.row_neg);
        col_mag     = signed_mag(col_base_reg, col_prod_reg, ctl_reg.col_neg);
        sum         = row_mag + col_mag;
        sum_adj     = sum + (MAG_BITS + 1)'(sum[MAG_BITS]);
        half        = sum_adj >>> 1;
        sample_next = ctl_reg.in_tone ? half[SAMPLE_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            ctl_reg       <= ctl_next;
            out_valid_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            row_base_reg   <= row_terms.base;
            row_prod_reg   <= row_terms.prod;
            col_base_reg   <= col_terms.base;
            col_prod_reg   <= col_terms.prod;
            sample_reg     <= sample_next;
            in_tone_reg    <= ctl_reg.in_tone;
            burst_last_reg <= ctl_reg.burst_last;
            bad_key_reg    <= ctl_reg.bad_key;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample     = sample_reg;
    assign in_tone    = in_tone_reg;
    assign burst_last = burst_last_reg;
    assign bad_key    = bad_key_reg;

endmodule

/* hdl/dtmf_tone_burst_generator.sv */
// DTMF tone burst generator top level: one input word per sample tick, one sample word out.
//
// Every accepted word on key_in yields exactly one word on tone_out, in order, after
// three register stages; while tone_out is not stalled a new word is taken in every
// cycle for a sustained rate of one sample per clock. The stages are: the sequencer
// registers (key decode, counters, phase accumulators) loaded at the accepting edge
// together with the registered read of the sine table, which is split into an even
// and an odd bank so that both interpolation neighbours come out of one read per bank;
// then the mixer's multiply register (one multiply per sine); then the output register
// after round, sign and average. The whole pipeline holds while the output word waits,
// so key_in.ready drops only then. The sine table is a constant ROM and needs no
// clearing pass after reset. tone_ms and gap_ms are written through
// cfg_we/cfg_index/cfg_wdata; the write turns milliseconds into a sample count at once,
// and the new length takes effect at the next start. Write them only while no burst
// words are in flight.
`include "dtmf_tone_burst_generator_defines.svh"

module dtmf_tone_burst_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    dtmf_key_if.sink                            key_in,
    dtmf_sample_if.source                       tone_out,
    input  logic                                cfg_we,
    input  logic [dtmf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  dtmf_pkg::ms_t                       cfg_wdata
);
    import dtmf_pkg::*;

    logic                advance;
    logic [TBL_BITS-1:0] row_lo, col_lo;
    rom_word_t           row_even, row_odd, col_even, col_odd;
    lane_t               lane;

    // Advance every stage unless a finished word is waiting at the output
    assign advance      = !tone_out.valid || tone_out.ready;
    assign key_in.ready = advance;

    // Apply starts, step the counters and phases, address the table
    dtmf_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (key_in.valid),
        .start_burst (key_in.start_burst),
        .key_code    (key_in.key_code),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .row_lo      (row_lo),
        .col_lo      (col_lo),
        .lane        (lane)
    );

    // One table copy per sine so both lookups finish in the same cycle
    dtmf_sine_rom u_row_rom (
        .clk    (clk),
        .en     (advance),
        .lo     (row_lo),
        .even_q (row_even),
        .odd_q  (row_odd)
    );

    dtmf_sine_rom u_col_rom (
        .clk    (clk),
        .en     (advance),
        .lo     (col_lo),
        .even_q (col_even),
        .odd_q  (col_odd)
    );

    // Interpolate, combine and hold the output word
    dtmf_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .lane       (lane),
        .row_even   (row_even),
        .row_odd    (row_odd),
        .col_even   (col_even),
        .col_odd    (col_odd),
        .out_valid  (tone_out.valid),
        .sample     (tone_out.sample),
        .in_tone    (tone_out.in_tone),
        .burst_last (tone_out.burst_last),
        .bad_key    (tone_out.bad_key)
    );

    // A stalled output word must freeze the input side
    `DTMF_ASSERT_NOW(a_stall_blocks_input, tone_out.valid && !tone_out.ready, !key_in.ready, "input taken while output word stalled")
    // An unknown key stops the burst and gives silence
    `DTMF_ASSERT_NOW(a_bad_key_silent, tone_out.valid && tone_out.bad_key, !tone_out.in_tone && !tone_out.burst_last && tone_out.sample == '0, "bad key word not silent")
    // Outside the tone part the sample is zero
    `DTMF_ASSERT_NOW(a_gap_silent, tone_out.valid && !tone_out.in_tone, tone_out.sample == '0, "non-zero sample outside tone")
    // A word stalled at the output is still there next cycle
    `DTMF_ASSERT_NEXT(a_stalled_word_kept, tone_out.valid && !tone_out.ready, tone_out.valid, "stalled output word dropped")

endmodule

/* bench/dtmf_tone_burst_generator_tb.sv */
// Self-checking testbench of the DTMF tone burst generator: keyed bursts against a predictor.
`timescale 1ns / 1ps

module dtmf_tone_burst_generator_tb;
    import dtmf_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    // Pipeline is three stages deep; leave a little more than that before a register write
    localparam int SETTLE_CYCLES  = 5;
    localparam int TAIL_CYCLES    = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int IDLE_PCT       = 10;
    localparam int PLAIN_KEY_PCT  = 80;

    localparam ms_t                  RESET_MS   = 100;
    localparam ms_t                  MS_MAX     = '1;
    localparam logic [KEY_BITS-1:0]  KEY_NUL    = 8'h00;
    localparam logic [KEY_BITS-1:0]  KEY_ONES   = 8'hFF;
    localparam longint unsigned      HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned      PHASE_MASK  = (64'd1 << PHASE_BITS) - 64'd1;
    localparam longint unsigned      COUNT_MAX   = (64'd1 << CNT_BITS) - 64'd1;

    // Keypad laid out row by row: the position of a symbol is row*4 + column
    localparam logic [KEY_BITS-1:0] KEYPAD [16] = '{
        "1", "2", "3", "A",
        "4", "5", "6", "B",
        "7", "8", "9", "C",
        "*", "0", "#", "D"
    };
    localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
    localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};

    // One output word as the block should present it
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          in_tone;
        logic                          burst_last;
        logic                          bad_key;
    } tone_word_t;

    // Burst tracker: mirrors the generator state and keeps the words still owed by the block.
    class burst_tracker;
        int unsigned     quarter_wave [SINE_TABLE_DEPTH+1];
        ms_t             tone_ms;
        ms_t             gap_ms;
        phase_t          row_acc;
        phase_t          col_acc;
        phase_t          row_inc;
        phase_t          col_inc;
        count_t          tone_left;
        count_t          gap_left;
        tone_word_t      due_words [$];
        int unsigned     errors;

        function new();
            tone_ms   = RESET_MS;
            gap_ms    = RESET_MS;
            row_acc   = '0;
            col_acc   = '0;
            row_inc   = '0;
            col_inc   = '0;
            tone_left = '0;
            gap_left  = '0;
            errors    = 0;
            for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
                quarter_wave[k] = quarter_sine(k);
        endfunction

        // Taylor series of sin(pi/2 * k/depth) in Q30, rounded to Q1.15
        function int unsigned quarter_sine(int unsigned k);
            longint unsigned x;
            longint unsigned term;
            longint          sum;
            longint unsigned scaled;
            x    = (HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (longint'(1) <<< 30))
                sum = longint'(1) <<< 30;
            scaled = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
            return scaled[31:0];
        endfunction

        // Interpolated table read of one sine at the given phase
        function int sine_of(phase_t p);
            longint unsigned scaled;
            longint unsigned idx;
            longint unsigned frac;
            longint unsigned a;
            longint unsigned b;
            longint unsigned mag;
            int unsigned     quad;
            int unsigned     k;
            scaled = 64'(p) * (4 * SINE_TABLE_DEPTH);
            idx    = scaled >> PHASE_BITS;
            frac   = (scaled & PHASE_MASK) >> (PHASE_BITS - 16);
            quad   = 32'((idx / SINE_TABLE_DEPTH) % 4);
            k      = 32'(idx % SINE_TABLE_DEPTH);
            if (quad[0])
            begin
                a = quarter_wave[SINE_TABLE_DEPTH - k];
                b = quarter_wave[SINE_TABLE_DEPTH - k - 1];
            end
            else
            begin
                a = quarter_wave[k];
                b = quarter_wave[k + 1];
            end
            mag = (a * (65536 - frac) + b * frac + 32768) >> 16;
            return quad[1] ? -int'(mag) : int'(mag);
        endfunction

        function phase_t step_for(int unsigned hz);
            longint unsigned s;
            s = ((64'(hz) << PHASE_BITS) + SAMPLE_RATE / 2) / SAMPLE_RATE;
            return s[PHASE_BITS-1:0];
        endfunction

        function count_t frames_for(ms_t ms);
            longint unsigned n;
            n = (64'(ms) * SAMPLE_RATE) / 1000;
            if (n > COUNT_MAX)
                n = COUNT_MAX;
            return n[CNT_BITS-1:0];
        endfunction

        function int key_cell(logic [KEY_BITS-1:0] code);
            for (int i = 0; i < 16; i++)
                if (KEYPAD[i] == code)
                    return i;
            return -1;
        endfunction

        function void set_length(cfg_reg_t idx, ms_t value);
            if (idx == REG_TONE_MS)
                tone_ms = value;
            else
                gap_ms = value;
        endfunction

        // Note one accepted input word and queue the sample it produces
        function void take_key(logic start, logic [KEY_BITS-1:0] code);
            tone_word_t w;
            int         pos;
            int         mix;
            w = '0;
            if (start)
            begin
                pos = key_cell(code);
                if (pos < 0)
                begin
                    w.bad_key = 1'b1;
                    tone_left = '0;
                    gap_left  = '0;
                end
                else
                begin
                    row_inc   = step_for(ROW_HZ[pos / 4]);
                    col_inc   = step_for(COL_HZ[pos % 4]);
                    row_acc   = '0;
                    col_acc   = '0;
                    tone_left = frames_for(tone_ms);
                    gap_left  = frames_for(gap_ms);
                end
            end
            if (tone_left != 0)
            begin
                mix          = (sine_of(row_acc) + sine_of(col_acc)) / 2;
                w.sample     = mix[SAMPLE_BITS-1:0];
                row_acc      = row_acc + row_inc;
                col_acc      = col_acc + col_inc;
                tone_left    = tone_left - 1'b1;
                w.in_tone    = 1'b1;
                w.burst_last = (tone_left == 0) && (gap_left == 0);
            end
            else if (gap_left != 0)
            begin
                gap_left     = gap_left - 1'b1;
                w.burst_last = (gap_left == 0);
            end
            due_words.push_back(w);
        endfunction

        function void compare_field(string field, logic signed [31:0] want_v,
                                    logic signed [31:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want_v, got_v);
            end
        endfunction

        // Check one accepted output word against the oldest owed word
        function void match_sample(tone_word_t got);
            tone_word_t want;
            if (due_words.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, actual sample %0d",
                             $time, got.sample);
                return;
            end
            want = due_words.pop_front();
            compare_field("sample", want.sample, got.sample);
            compare_field("in_tone", want.in_tone, got.in_tone);
            compare_field("burst_last", want.burst_last, got.burst_last);
            compare_field("bad_key", want.bad_key, got.bad_key);
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    ms_t                         cfg_wdata;

    dtmf_key_if    key_bus ();
    dtmf_sample_if tone_bus ();

    burst_tracker tracker = new();

    // calm: no idling on either side; hold_pending: ask the sample side for a long hold-off
    bit          calm;
    bit          hold_pending;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    dtmf_tone_burst_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_in    (key_bus),
        .tone_out  (tone_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly real keypad symbols; the rest is any byte, which may or may not be a key
    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 99) < PLAIN_KEY_PCT)
            return KEYPAD[$urandom_range(0, 15)];
        return KEY_BITS'($urandom_range(0, 255));
    endfunction

    // Offer one word, maybe after a few idle cycles, and hold it until the block takes it.
    // The word is noted in the tracker at the edge that accepts it.
    task automatic send_word(input logic start, input logic [KEY_BITS-1:0] code);
        int unsigned gap_cycles;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap_cycles = $urandom_range(1, 3);
            repeat (gap_cycles)
            begin
                key_bus.valid       <= 1'b0;
                key_bus.start_burst <= 1'($urandom_range(0, 1));
                key_bus.key_code    <= KEY_BITS'($urandom_range(0, 255));
                @(posedge clk);
            end
        end
        key_bus.valid       <= 1'b1;
        key_bus.start_burst <= start;
        key_bus.key_code    <= code;
        do
            @(posedge clk);
        while (!key_bus.ready);
        tracker.take_key(start, code);
    endtask

    // Write both lengths once the block has drained: every owed word back, then a few
    // cycles so that nothing is left inside the pipeline.
    task automatic write_lengths(input ms_t tone, input ms_t gap);
        while (tracker.due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TONE_MS;
        cfg_wdata <= tone;
        tracker.set_length(REG_TONE_MS, tone);
        @(posedge clk);
        cfg_index <= REG_GAP_MS;
        cfg_wdata <= gap;
        tracker.set_length(REG_GAP_MS, gap);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One setting of the lengths followed by a run of sample ticks. Starts come at
    // start_pct percent; idle ticks carry junk in key_code, which must be ignored.
    task automatic run_phase(input ms_t tone, input ms_t gap, input int ticks,
                             input int start_pct, input bit with_hold);
        logic start;
        write_lengths(tone, gap);
        hold_pending = with_hold;
        for (int i = 0; i < ticks; i++)
        begin
            start = ($urandom_range(0, 99) < start_pct);
            send_word(start, start ? pick_key() : KEY_BITS'($urandom_range(0, 255)));
        end
        key_bus.valid <= 1'b0;
    endtask

    // Sample side: check each accepted word, then pick ready for the next edge. A hold-off
    // request keeps ready low until the hold_left counter runs out, so the pipeline fills up
    // and the key side stalls.
    initial
    begin
        tone_bus.ready = 1'b0;
        hold_left      = 0;
        forever
        begin
            @(posedge clk);
            if (tone_bus.valid && tone_bus.ready)
                tracker.match_sample('{tone_bus.sample, tone_bus.in_tone,
                                       tone_bus.burst_last, tone_bus.bad_key});
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                tone_bus.ready <= 1'b0;
            end
            else
                tone_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: count edges at which neither side moves a word
    initial
    begin
        quiet_cycles = 0;
        do
        begin
            @(posedge clk);
            if ((key_bus.valid && key_bus.ready) || (tone_bus.valid && tone_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_TONE_MS;
        cfg_wdata           = '0;
        key_bus.valid       = 1'b0;
        key_bus.start_burst = 1'b0;
        key_bus.key_code    = '0;
        calm                = 1'b0;
        hold_pending        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset lengths (100 ms each, far longer than these ticks).
        // Idle ticks with key_code at both extremes: silence, no flags.
        send_word(1'b0, KEY_ONES);
        send_word(1'b0, KEY_NUL);
        // Every key back to back: each start restarts the burst from phase zero
        foreach (KEYPAD[i])
            send_word(1'b1, KEYPAD[i]);
        // Let the last tone run for a couple of samples
        send_word(1'b0, 8'hA5);
        send_word(1'b0, 8'h5A);
        // Unknown key in the middle of a burst: flag it and drop to silence
        send_word(1'b1, KEY_NUL);
        send_word(1'b0, 8'h35);
        // Fresh burst, then cut by the all-ones code
        send_word(1'b1, "5");
        send_word(1'b0, 8'h00);
        send_word(1'b1, KEY_ONES);
        send_word(1'b0, 8'hFF);
        key_bus.valid <= 1'b0;

        // Random part: short bursts so that many of them run to their last sample.
        // Tone only: burst_last lands on the final tone sample.
        run_phase(ms_t'(1), ms_t'(0), 150, 2, 1'b0);
        // Gap only: silent bursts that still end with burst_last
        run_phase(ms_t'(0), ms_t'(1), 120, 3, 1'b0);
        // Empty bursts: every start of a known key behaves as an idle tick
        run_phase(ms_t'(0), ms_t'(0), 60, 30, 1'b0);
        // No idling at all, and one long hold-off on the sample side while keys keep coming
        calm = 1'b1;
        run_phase(ms_t'(1), ms_t'(1), 200, 2, 1'b1);
        calm = 1'b0;
        run_phase(ms_t'(2), ms_t'(1), 200, 1, 1'b0);
        // Longest lengths the registers hold; restarts and bad keys cut these short
        run_phase(MS_MAX, MS_MAX, 100, 5, 1'b0);
        run_phase(ms_t'(0), MS_MAX, 60, 5, 1'b0);
        run_phase(ms_t'(1), ms_t'(2), 240, 1, 1'b0);

        // Drain: wait for every owed word, then a few more edges for any stray output
        while (tracker.due_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
